// ----- rtl/tccs_pkg.sv -----
package tccs_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Character and attribute codes
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // Start points for the cell sweep counter
  typedef enum logic [1:0] {
    SW_ZERO   = 2'd0,
    SW_COPY   = 2'd1,
    SW_BOTTOM = 2'd2
  } sweep_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       sweep_set;
    sweep_sel_t sweep_sel;
    logic       fill_step;
    logic       fill_reset_attr;
    logic       copy_step;
    logic       rd_issue;
    logic       put_write;
    logic       cur_newline;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_nl;
    logic col_full;
    logic row_last;
    logic sweep_last;
  } status_t;

endpackage

// ----- rtl/text_console_cursor_scroll_unit.sv -----
// Text console, ROWS x COLUMNS cells. Put character writes the character at the cursor (a
// newline code only moves the cursor); on a wrap it first takes a new line. Read cell issues
// one store read. Clear fills every cell through the single store write port. A scroll adds
// a copy, a drain and a blank of the bottom row. One item at a time; busy stays high until
// the strobe cycle ends; the receiver cannot stall. Synchronous reset starts a clearing pass
// over every cell with busy high; configuration words are taken only while idle with start low.
module text_console_cursor_scroll_unit #(
  parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [7:0] char_code,
  input  logic [4:0] query_row,
  input  logic [6:0] query_column,
  output logic       done,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic [4:0] cursor_row_now,
  output logic [6:0] cursor_col_now,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import tccs_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // Take the attribute word only between items
  assign cfg_ready = ~busy & ~start;

  tccs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  tccs_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .char_code      (char_code),
    .query_row      (query_row),
    .query_column   (query_column),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_data       (cfg_data),
    .cell_char      (cell_char),
    .cell_attr      (cell_attr),
    .cursor_row_now (cursor_row_now),
    .cursor_col_now (cursor_col_now)
  );

endmodule

// ----- rtl/tccs_ctrl.sv -----
module tccs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       kind,
  input  tccs_pkg::status_t stat,
  output tccs_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             done
);
  import tccs_pkg::*;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PUT   = 9'b000000100,
    S_READ  = 9'b000001000,
    S_CLEAR = 9'b000010000,
    S_COPY  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_BLANK = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sweep_sel = SW_ZERO;
    unique case (state)
      S_INIT: begin
        cmd.fill_step       = 1'b1;
        cmd.fill_reset_attr = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          cmd.sweep_set = 1'b1;
          cmd.sweep_sel = SW_ZERO;
          case (kind)
            KIND_PUT:   state_next = S_PUT;
            KIND_READ:  state_next = S_READ;
            KIND_CLEAR: state_next = S_CLEAR;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_PUT: begin
        if (stat.is_nl || stat.col_full) begin
          // Take a new line; scroll from the bottom row
          cmd.cur_newline = 1'b1;
          if (stat.row_last) begin
            cmd.sweep_set = 1'b1;
            cmd.sweep_sel = SW_COPY;
            state_next    = S_COPY;
          end else if (stat.is_nl) begin
            state_next = S_DONE;
          end
        end else begin
          cmd.put_write = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_DONE;
      end
      S_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (stat.sweep_last) state_next = S_DONE;
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.sweep_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        // Last copy word lands this cycle
        cmd.sweep_set = 1'b1;
        cmd.sweep_sel = SW_BOTTOM;
        state_next    = S_BLANK;
      end
      S_BLANK: begin
        cmd.fill_step = 1'b1;
        if (stat.sweep_last) state_next = stat.is_nl ? S_DONE : S_PUT;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ----- rtl/tccs_dpath.sv -----
module tccs_dpath #(
  parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  tccs_pkg::cmd_t    cmd,
  output tccs_pkg::status_t stat,
  input  logic [1:0]        kind,
  input  logic [7:0]        char_code,
  input  logic [4:0]        query_row,
  input  logic [6:0]        query_column,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  output logic [7:0]        cell_char,
  output logic [7:0]        cell_attr,
  output logic [4:0]        cursor_row_now,
  output logic [6:0]        cursor_col_now
);
  import tccs_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);

  logic [15:0]       mem [CELLS];
  logic [15:0]       mem_rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [7:0]        text_attribute;
  logic [1:0]        item_kind;
  logic [7:0]        item_char;
  logic [4:0]        item_qr;
  logic [6:0]        item_qc;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [ADDR_W-1:0] sweep_addr;
  logic              copy_wr;
  logic [ADDR_W-1:0] copy_waddr;
  logic              row_last;
  logic              query_ok;
  logic [ADDR_W-1:0] query_addr;
  logic [ADDR_W-1:0] cursor_addr;
  logic [7:0]        fill_attr;

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= RESET_ATTR;
    end else if (cfg_we) begin
      text_attribute <= cfg_data;
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind <= kind;
      item_char <= char_code;
      item_qr   <= query_row;
      item_qc   <= query_column;
    end
  end

  assign row_last = (cursor_row == ROW_W'(ROWS - 1));

  // Cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= ROW_W'(1);
      cursor_col <= '0;
    end else if (cmd.cur_newline) begin
      cursor_col <= '0;
      if (!row_last) cursor_row <= cursor_row + ROW_W'(1);
    end else if (cmd.put_write) begin
      cursor_col <= cursor_col + COL_W'(1);
    end
  end

  // Sweep counter over the cell store
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_set) begin
      case (cmd.sweep_sel)
        SW_COPY:   sweep_addr <= ADDR_W'(COLUMNS);
        SW_BOTTOM: sweep_addr <= ADDR_W'(CELLS - COLUMNS);
        default:   sweep_addr <= '0;
      endcase
    end else if (cmd.fill_step || cmd.copy_step) begin
      sweep_addr <= sweep_addr + ADDR_W'(1);
    end
  end

  // Copy write follows its read in the next cycle, one row lower in address
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_wr <= 1'b0;
    end else begin
      copy_wr <= cmd.copy_step;
    end
  end

  always_ff @(posedge clk) begin
    copy_waddr <= sweep_addr - ADDR_W'(COLUMNS);
  end

  assign query_ok = (32'(item_qr) < 32'(ROWS)) && (32'(item_qc) < 32'(COLUMNS));
  assign query_addr  = ADDR_W'(32'(item_qr) * 32'(COLUMNS) + 32'(item_qc));
  assign cursor_addr = ADDR_W'(32'(cursor_row) * 32'(COLUMNS) + 32'(cursor_col));
  assign fill_attr   = cmd.fill_reset_attr ? RESET_ATTR : text_attribute;

  // Select the store ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = {fill_attr, SPACE_CODE};
    if (copy_wr) begin
      mem_we    = 1'b1;
      mem_waddr = copy_waddr;
      mem_wdata = mem_rdata;
    end else if (cmd.fill_step) begin
      mem_we = 1'b1;
    end else if (cmd.put_write) begin
      mem_we    = 1'b1;
      mem_waddr = cursor_addr;
      mem_wdata = {text_attribute, item_char};
    end
    mem_re    = cmd.copy_step || cmd.rd_issue;
    mem_raddr = cmd.copy_step ? sweep_addr : query_addr;
  end

  // Cell store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  assign stat.is_nl      = (item_char == NEWLINE_CODE);
  assign stat.col_full   = (32'(cursor_col) >= 32'(COLUMNS));
  assign stat.row_last   = row_last;
  assign stat.sweep_last = (sweep_addr == ADDR_W'(CELLS - 1));

  // Result fields
  always_comb begin
    cell_char = '0;
    cell_attr = '0;
    if (item_kind == KIND_READ && query_ok) begin
      cell_char = mem_rdata[7:0];
      cell_attr = mem_rdata[15:8];
    end
  end

  assign cursor_row_now = 5'(cursor_row);
  assign cursor_col_now = 7'(cursor_col);

endmodule
